// ----- src/bba_pkg.sv -----
// Shared definitions for the bitmap block allocator.
// Holds field widths, status and mode codes, defaults and the result struct.
// No dependencies.
package bba_pkg;

  localparam int CFG_W = 10;
  localparam int BLK_W = 9;
  localparam int ST_W  = 2;

  localparam int MAX_BLOCKS_DEF    = 512;
  localparam int MAP_WORD_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] PART_SIZE_RST = 10'd512;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic             done;
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] granted;
  } bba_result_t;

endpackage

// ----- src/bba_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/bba_engine.sv -----
// Request sequencer of the bitmap block allocator: map clearing, word scan,
// read-modify-write of one map word. Depends on bba_pkg; drives a bba_ram.
module bba_engine import bba_pkg::*; #(
  parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF,
  localparam int MAP_WORDS    = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
  localparam int AW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     mode,
  input  logic [BLK_W-1:0]         block_number,
  input  logic [CFG_W-1:0]         part_size,
  output logic                     busy,
  output bba_result_t              result,
  output logic                     ram_wr_en,
  output logic [AW-1:0]            ram_wr_addr,
  output logic [MAP_WORD_BITS-1:0] ram_wr_data,
  output logic                     ram_rd_en,
  output logic [AW-1:0]            ram_rd_addr,
  input  logic [MAP_WORD_BITS-1:0] ram_rd_data
);

  localparam int OFF_W  = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
  localparam int BASE_W = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
  localparam int CMP_W  = (BASE_W > CFG_W) ? BASE_W : CFG_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} state_t;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic [AW:0]        scan_addr;
  logic [BASE_W-1:0]  scan_base;
  logic               pend;
  logic [AW-1:0]      eval_addr;
  logic [BASE_W-1:0]  eval_base;
  logic               req_free;
  logic [BLK_W-1:0]   req_blk;
  logic [BASE_W-1:0]  lim;

  logic [CMP_W-1:0]         lim_wide;
  logic [BASE_W-1:0]        lim_now;
  logic                     issue_ok;
  logic [CMP_W-1:0]         base_ext;
  logic [CMP_W-1:0]         rem;
  logic [MAP_WORD_BITS-1:0] free_bits;
  logic                     found_alloc;
  logic [OFF_W-1:0]         alloc_idx;
  logic [CMP_W-1:0]         blk_ext;
  logic [CMP_W-1:0]         blk_diff;
  logic                     in_word;
  logic [OFF_W-1:0]         off;
  logic                     bit_set;
  logic                     hit;
  logic [CMP_W-1:0]         grant_c;

  // Partition size above the map size is clamped to the map size.
  assign lim_wide = (CMP_W'(part_size) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                             : CMP_W'(part_size);
  assign lim_now  = lim_wide[BASE_W-1:0];

  assign issue_ok = (scan_addr < (AW+1)'(MAP_WORDS)) && (scan_base < lim);

  assign base_ext = CMP_W'(eval_base);
  assign rem      = CMP_W'(lim) - base_ext;

  always_comb begin
    free_bits   = '0;
    found_alloc = 1'b0;
    alloc_idx   = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      free_bits[b] = ~ram_rd_data[b] && (CMP_W'(b) < rem);
    end
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_alloc = 1'b1;
        alloc_idx   = OFF_W'(b);
      end
    end
  end

  assign blk_ext  = CMP_W'(req_blk);
  assign blk_diff = blk_ext - base_ext;
  assign in_word  = (blk_ext >= base_ext) && (blk_diff < CMP_W'(MAP_WORD_BITS));
  assign off      = blk_diff[OFF_W-1:0];
  assign bit_set  = ram_rd_data[off];
  assign hit      = pend && (req_free ? in_word : found_alloc);
  assign grant_c  = base_ext + CMP_W'(alloc_idx);

  assign busy = (state != S_IDLE);

  always_comb begin
    ram_rd_en   = (state == S_SCAN) && issue_ok;
    ram_rd_addr = scan_addr[AW-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = eval_addr;
    ram_wr_data = ram_rd_data | (MAP_WORD_BITS'(1) << alloc_idx);
    case (state)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = (clr_addr == '0) ? MAP_WORD_BITS'(1) : '0;
      end
      S_SCAN: begin
        ram_wr_en = hit && (!req_free || bit_set);
        if (req_free) begin
          ram_wr_data = ram_rd_data & ~(MAP_WORD_BITS'(1) << off);
        end
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      pend        <= 1'b0;
      result.done <= 1'b0;
    end else begin
      result.done <= 1'b0;
      pend        <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_free  <= (mode == MODE_FREE);
            req_blk   <= block_number;
            lim       <= lim_now;
            scan_addr <= '0;
            scan_base <= '0;
            if ((mode == MODE_FREE) && (CMP_W'(block_number) >= CMP_W'(lim_now))) begin
              result.done    <= 1'b1;
              result.status  <= ST_BAD;
              result.granted <= '0;
            end else if ((mode == MODE_ALLOC) && (lim_now == '0)) begin
              result.done    <= 1'b1;
              result.status  <= ST_FULL;
              result.granted <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend      <= issue_ok;
          eval_addr <= scan_addr[AW-1:0];
          eval_base <= scan_base;
          scan_addr <= scan_addr + 1'b1;
          scan_base <= scan_base + BASE_W'(MAP_WORD_BITS);
          if (hit) begin
            state          <= S_IDLE;
            result.done    <= 1'b1;
            result.status  <= (req_free && !bit_set) ? ST_BAD : ST_OK;
            result.granted <= req_free ? '0 : grant_c[BLK_W-1:0];
          end else if (!issue_ok) begin
            state          <= S_IDLE;
            result.done    <= 1'b1;
            result.status  <= req_free ? ST_BAD : ST_FULL;
            result.granted <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/bitmap_block_allocator_top.sv -----
// Top level of the bitmap block allocator: partition size register, request
// sequencer and the allocation map RAM. Depends on bba_pkg, bba_engine, bba_ram.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low; mode selects allocate (lowest free block below the partition size) or
// free (clear the used bit of block_number). Exactly one result follows: done
// is high for one cycle with status and block_granted valid in that cycle.
// The receiver cannot hold results off; it must take them when done is high.
//
// The map sits in a RAM of MAP_WORDS words of MAP_WORD_BITS bits (16 words of
// 32 bits by default), read through a registered port. A request walks the
// map one word per cycle from word 0 and, on success, modifies and writes
// back the word it stops at. A free request outside the partition, or an
// allocate with a partition size of zero, gives done in the cycle right after
// it is taken. busy is high while a request is scanning; a new request can be
// taken in the cycle where done is high.
//
// The partition size register is written through cfg_valid/cfg_data; it is
// always ready and is meant to be written only while no request is pending.
// After reset the block clears the map one word at a time, leaving only
// block 0 marked used; busy stays high during that pass, and the partition
// size returns to 512.
module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             mode,
  input  logic [BLK_W-1:0] block_number,
  output logic             done,
  output logic [ST_W-1:0]  status,
  output logic [BLK_W-1:0] block_granted,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [CFG_W-1:0]         part_size;
  bba_result_t              result;
  logic                     ram_wr_en;
  logic [AW-1:0]            ram_wr_addr;
  logic [MAP_WORD_BITS-1:0] ram_wr_data;
  logic                     ram_rd_en;
  logic [AW-1:0]            ram_rd_addr;
  logic [MAP_WORD_BITS-1:0] ram_rd_data;

  // The register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_size <= PART_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      part_size <= cfg_data;
    end
  end

  bba_engine #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .block_number (block_number),
    .part_size    (part_size),
    .busy         (busy),
    .result       (result),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result fields are forced to zero outside the strobe cycle.
  assign done          = result.done;
  assign status        = result.done ? result.status : ST_OK;
  assign block_granted = result.done ? result.granted : '0;

endmodule

// ----- src/bba_checker.sv -----
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_top.
module bba_checker import bba_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [ST_W-1:0]  status,
  input logic [BLK_W-1:0] block_granted
);

  // The block starts its map clearing pass right after reset.
  a_busy_after_reset: assert property (@(posedge clk) $past(rst) |-> busy)
    else $error("busy low in the cycle after reset");

  // A result only follows a request taken at the last edge or one in progress.
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a request");

  // A failed request carries no block number.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (block_granted == '0))
    else $error("nonzero block number on a failed request");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == ST_OK) || (status == ST_FULL) || (status == ST_BAD)))
    else $error("undefined status code");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (.*);

// ----- test/bitmap_block_allocator_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_block_allocator_top: directed and random
// allocate and free requests, checked against a bit map kept in the bench.
// Depends on bba_pkg and the allocator RTL.
module bitmap_block_allocator_top_test;
  import bba_pkg::*;

  // One expected result: what the allocator must report for one request.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] granted;
  } alloc_outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             mode = MODE_ALLOC;
  logic [BLK_W-1:0] block_number = '0;
  logic             done;
  logic [ST_W-1:0]  status;
  logic [BLK_W-1:0] block_granted;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // The bench's own copy of the allocation map and of the partition size.
  // Both are updated at the clock edge where the DUT takes the request or the
  // register write, so they always match what the DUT should hold.
  bit [MAX_BLOCKS_DEF-1:0] shadow_map;
  logic [CFG_W-1:0]        shadow_size;

  // Results still owed by the DUT, oldest first.
  alloc_outcome_t expected_outcomes[$];
  alloc_outcome_t last_prediction;

  int errors = 0;
  int n_requests = 0;
  int n_ok = 0;
  int n_full = 0;
  int n_bad = 0;
  int n_size_writes = 0;
  bit idle_enabled = 1'b1;

  always #4 clk = ~clk;

  bitmap_block_allocator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .block_number (block_number),
    .done         (done),
    .status       (status),
    .block_granted(block_granted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Sizes above the map are clamped to the map.
  function automatic int part_limit();
    if (shadow_size > MAX_BLOCKS_DEF) begin
      return MAX_BLOCKS_DEF;
    end
    return int'(shadow_size);
  endfunction

  // First-fit allocation and checked free on the shadow map. Bits at or above
  // the partition size are never granted and never freed, but keep their value.
  function automatic alloc_outcome_t predict_request(input logic req_mode,
                                                     input logic [BLK_W-1:0] blk);
    alloc_outcome_t res;
    int lim;
    lim = part_limit();
    res.status = ST_BAD;
    res.granted = '0;
    if (req_mode == MODE_ALLOC) begin
      res.status = ST_FULL;
      for (int b = 0; b < lim; b++) begin
        if (!shadow_map[b]) begin
          shadow_map[b] = 1'b1;
          res.status = ST_OK;
          res.granted = BLK_W'(b);
          break;
        end
      end
    end else if (int'(blk) < lim && shadow_map[blk]) begin
      shadow_map[blk] = 1'b0;
      res.status = ST_OK;
    end
    return res;
  endfunction

  // A block that a free request will accept, if there is one; otherwise any
  // block number, which the DUT must reject.
  function automatic logic [BLK_W-1:0] pick_used_block();
    int candidates[$];
    int lim;
    lim = part_limit();
    for (int b = 0; b < lim; b++) begin
      if (shadow_map[b]) begin
        candidates.push_back(b);
      end
    end
    if (candidates.size() == 0) begin
      return BLK_W'($urandom);
    end
    return BLK_W'(candidates[$urandom_range(0, candidates.size() - 1)]);
  endfunction

  // Presents one request and holds it until the DUT takes it. start is left
  // high on return, so back-to-back requests go out without a gap; a random
  // gap lowers it first, in a different time step from the next raise.
  task automatic send_request(input logic req_mode, input logic [BLK_W-1:0] blk);
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    start <= 1'b1;
    mode <= req_mode;
    block_number <= blk;
    do @(posedge clk); while (busy);
    last_prediction = predict_request(req_mode, blk);
    expected_outcomes.push_back(last_prediction);
    n_requests++;
  endtask

  task automatic stop_requests();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // The size register is only written with the allocator idle: no request on
  // the port, every result back, and a few cycles for the scan to settle.
  task automatic write_partition_size(input logic [CFG_W-1:0] value);
    stop_requests();
    while (expected_outcomes.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_size = value;
    n_size_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // First fit after reset, reuse of a freed hole, double free, returning the
  // map block 0 and the block number being ignored on allocate.
  task automatic test_first_fit_order();
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '1);
    send_request(MODE_ALLOC, 9'h0AA);
    send_request(MODE_FREE, 9'd2);
    send_request(MODE_FREE, 9'd2);
    send_request(MODE_ALLOC, 9'h155);
    send_request(MODE_FREE, 9'd0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 9'd511);
    send_request(MODE_ALLOC, '1);
  endtask

  // Size zero, oversize clamping, a tiny partition running full, and a shrink
  // that leaves used bits above the new size untouchable.
  task automatic test_partition_edges();
    write_partition_size(10'd0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 9'd1);
    send_request(MODE_FREE, 9'd0);
    write_partition_size(10'd1023);
    send_request(MODE_ALLOC, '0);
    write_partition_size(10'd6);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 9'd5);
    send_request(MODE_ALLOC, '0);
    write_partition_size(10'd3);
    send_request(MODE_FREE, 9'd4);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 9'd1);
    send_request(MODE_ALLOC, '0);
    write_partition_size(10'd1);
    send_request(MODE_FREE, 9'd0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
  endtask

  // Fills the whole map at full speed so the top blocks are granted, then
  // checks the last block can be returned and handed out again.
  task automatic test_fill_partition();
    idle_enabled = 1'b0;
    write_partition_size(PART_SIZE_RST);
    do begin
      send_request(MODE_ALLOC, BLK_W'($urandom));
    end while (last_prediction.status != ST_FULL);
    send_request(MODE_FREE, 9'd511);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    idle_enabled = 1'b1;
  endtask

  // Phases of mixed traffic, each under a new partition size. Most frees name
  // a block that is really in use; the rest are random numbers. One phase
  // runs with no gaps at all.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] size_pick;
    int alloc_pct;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0: size_pick = 10'd0;
        1: size_pick = 10'd1023;
        2: size_pick = PART_SIZE_RST;
        3: size_pick = CFG_W'($urandom_range(0, 1023));
        default: size_pick = CFG_W'($urandom_range(1, 48));
      endcase
      write_partition_size(size_pick);
      idle_enabled = (phase != 4);
      alloc_pct = $urandom_range(30, 80);
      repeat (42) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_request(MODE_ALLOC, BLK_W'($urandom));
        end else if ($urandom_range(0, 3) != 0) begin
          send_request(MODE_FREE, pick_used_block());
        end else begin
          send_request(MODE_FREE, BLK_W'($urandom));
        end
      end
    end
    idle_enabled = 1'b1;
  endtask

  // Every done pulse is matched against the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    alloc_outcome_t want;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: status %0d block_granted %0d", status, block_granted);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (block_granted !== want.granted) begin
          $error("block_granted: expected %0d, got %0d", want.granted, block_granted);
          errors++;
        end
        case (status)
          ST_OK:   n_ok++;
          ST_FULL: n_full++;
          default: n_bad++;
        endcase
      end
    end
  end

  initial begin : run_tests
    int waited;
    shadow_map = '0;
    shadow_map[0] = 1'b1;
    shadow_size = PART_SIZE_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The map clearing pass after reset keeps busy high, so the first request
    // simply waits for it.
    test_first_fit_order();
    test_partition_edges();
    test_fill_partition();
    test_random_traffic();

    // Let the last results drain, then allow a scan's worth of cycles for any
    // stray done pulse to show up.
    stop_requests();
    waited = 0;
    while (expected_outcomes.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (MAX_BLOCKS_DEF / MAP_WORD_BITS_DEF + 4) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      errors++;
    end

    $display("Sent %0d requests over %0d partition sizes, including a full map.",
             n_requests, n_size_writes);
    $display("Results seen: %0d success, %0d no free block, %0d rejected.",
             n_ok, n_full, n_bad);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
src/bba_pkg.sv
src/bba_ram.sv
src/bba_engine.sv
src/bitmap_block_allocator_top.sv
src/bba_checker.sv
test/bitmap_block_allocator_top_test.sv
